FILE: hdl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the sorted key/value table: field widths,
// command and status codes, payload structs and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

    localparam int KEY_W          = 32;
    localparam int VALUE_W        = 32;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;
    localparam int ENTRY_COUNT_W  = 8;
    localparam int CAPACITY_DEF   = 128;
    localparam int GROUP_SIZE_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } skvt_in_t;

    typedef struct packed {
        logic                       found;
        logic signed [VALUE_W-1:0]  found_value;
        logic [STATUS_W-1:0]        status;
        logic [ENTRY_COUNT_W-1:0]   entry_count;
    } skvt_out_t;

    // Per-cycle control broadcast to every cell of the row
    typedef struct packed {
        logic cmp;   // capture less-than / equal flags against the command key
        logic ins;   // open a gap at the insert point and drop in the new pair
        logic del;   // close the gap at the matching entry
        logic rep;   // overwrite the value of the matching entry
    } skvt_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/skvt_cell.sv
// ----------------------------------------------------------------------------
// skvt_cell
// One slot of the sorted row. Compares its key with the command key; on an
// update keeps its pair, takes a neighbor's pair, the new pair or a new value.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_cell
    import skvt_pkg::*;
#(
    parameter int CNT_W = 8,
    parameter int IDX   = 0
)
(
    input  wire logic                      clk,
    input  wire skvt_cell_ctrl_t           ctrl,
    input  wire logic [CNT_W-1:0]          count,
    input  wire logic signed [KEY_W-1:0]   cmd_key,
    input  wire logic signed [VALUE_W-1:0] cmd_value,
    input  wire logic                      left_lt,
    input  wire logic signed [KEY_W-1:0]   left_key,
    input  wire logic signed [VALUE_W-1:0] left_value,
    input  wire logic signed [KEY_W-1:0]   right_key,
    input  wire logic signed [VALUE_W-1:0] right_value,
    output logic signed [KEY_W-1:0]        key,
    output logic signed [VALUE_W-1:0]      value,
    output logic                           lt,
    output logic                           eq
);

    logic signed [KEY_W-1:0]   key_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      lt_reg;
    logic                      eq_reg;
    logic                      occupied;

    // Slot holds a live pair when its index is below the count
    assign occupied = (count > CNT_W'(IDX));

    // Compare, then shift or overwrite
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp)
        begin
            lt_reg <= occupied && (key_reg < cmd_key);
            eq_reg <= occupied && (key_reg == cmd_key);
        end
        if (ctrl.ins && !lt_reg)
        begin
            if (left_lt)
            begin
                key_reg   <= cmd_key;
                value_reg <= cmd_value;
            end
            else
            begin
                key_reg   <= left_key;
                value_reg <= left_value;
            end
        end
        if (ctrl.del && !lt_reg)
        begin
            key_reg   <= right_key;
            value_reg <= right_value;
        end
        if (ctrl.rep && eq_reg)
        begin
            value_reg <= cmd_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

FILE: hdl/skvt_group.sv
// ----------------------------------------------------------------------------
// skvt_group
// Registered match reduction over one group of cells: any-hit flag and the
// value of the matching cell (zero when none matches).
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_group
    import skvt_pkg::*;
#(
    parameter int GROUP_SIZE = GROUP_SIZE_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic [GROUP_SIZE-1:0]                eq,
    input  wire logic [GROUP_SIZE-1:0][VALUE_W-1:0]   vals,
    output logic                                      hit,
    output logic [VALUE_W-1:0]                        hit_value
);

    logic               hit_reg;
    logic [VALUE_W-1:0] hit_value_reg;
    logic               hit_next;
    logic [VALUE_W-1:0] hit_value_next;

    // Mask each value by its match flag and merge
    always_comb
    begin
        hit_next       = |eq;
        hit_value_next = '0;
        for (int i = 0; i < GROUP_SIZE; i++)
        begin
            hit_value_next = hit_value_next | (vals[i] & {VALUE_W{eq[i]}});
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg       <= hit_next;
        hit_value_reg <= hit_value_next;
    end

    assign hit       = hit_reg;
    assign hit_value = hit_value_reg;

endmodule

`default_nettype wire

FILE: hdl/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Operation: an accepted item passes through the states accept, cell compare,
// group reduce and finish; the result is registered on leaving finish, which
// waits while the output is held. A new item is taken only in the idle state.
// Reset: entry count clears to zero and the block is ready at once; cell
// contents are left undefined and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table
    import skvt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int GROUP_SIZE = GROUP_SIZE_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire skvt_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output skvt_out_t      out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NG    = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD   = NG * GROUP_SIZE;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_RED, S_FIN} state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    skvt_out_t         out_reg;
    skvt_out_t         out_next;
    skvt_in_t          cmd_reg;

    skvt_cell_ctrl_t   ctrl;
    logic              in_fire;
    logic              can_load;
    logic              advance;

    logic signed [KEY_W-1:0]    cell_key   [CAPACITY];
    logic signed [VALUE_W-1:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0]        lt_vec;
    logic [PAD-1:0]             eq_vec;
    logic [PAD-1:0][VALUE_W-1:0] val_vec;
    logic [NG-1:0]              grp_hit;
    logic [VALUE_W-1:0]         grp_val [NG];

    logic                       hit;
    logic [VALUE_W-1:0]         hit_value;
    logic                       full;
    logic [CNT_W+ENTRY_COUNT_W-1:0] count_wide;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign can_load  = !out_valid_reg || out_ready;
    assign advance   = (state_reg == S_FIN) && can_load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Hold the command for the whole operation
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= in_data;
        end
    end

    // Row of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                      l_lt;
            logic signed [KEY_W-1:0]   l_key;
            logic signed [VALUE_W-1:0] l_value;
            logic signed [KEY_W-1:0]   r_key;
            logic signed [VALUE_W-1:0] r_value;

            if (gi == 0)
            begin : g_left_edge
                assign l_lt    = 1'b1;
                assign l_key   = cmd_reg.key;
                assign l_value = cmd_reg.value;
            end
            else
            begin : g_left
                assign l_lt    = lt_vec[gi-1];
                assign l_key   = cell_key[gi-1];
                assign l_value = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_right_edge
                assign r_key   = cell_key[gi];
                assign r_value = cell_value[gi];
            end
            else
            begin : g_right
                assign r_key   = cell_key[gi+1];
                assign r_value = cell_value[gi+1];
            end

            skvt_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .cmd_key     (cmd_reg.key),
                .cmd_value   (cmd_reg.value),
                .left_lt     (l_lt),
                .left_key    (l_key),
                .left_value  (l_value),
                .right_key   (r_key),
                .right_value (r_value),
                .key         (cell_key[gi]),
                .value       (cell_value[gi]),
                .lt          (lt_vec[gi]),
                .eq          (eq_vec[gi])
            );

            assign val_vec[gi] = cell_value[gi];
        end

        // Pad the last group
        for (gi = CAPACITY; gi < PAD; gi++)
        begin : g_pad
            assign eq_vec[gi]  = 1'b0;
            assign val_vec[gi] = '0;
        end

        // Match reduction, one registered reducer per group
        for (gi = 0; gi < NG; gi++)
        begin : g_group
            skvt_group #(
                .GROUP_SIZE (GROUP_SIZE)
            ) u_group (
                .clk       (clk),
                .eq        (eq_vec[gi*GROUP_SIZE +: GROUP_SIZE]),
                .vals      (val_vec[gi*GROUP_SIZE +: GROUP_SIZE]),
                .hit       (grp_hit[gi]),
                .hit_value (grp_val[gi])
            );
        end
    endgenerate

    // Merge the group results
    always_comb
    begin
        hit       = |grp_hit;
        hit_value = '0;
        for (int g = 0; g < NG; g++)
        begin
            hit_value = hit_value | grp_val[g];
        end
    end

    assign full = (count_reg == CNT_W'(CAPACITY));

    // Decide the operation and build the result
    always_comb
    begin
        ctrl           = '0;
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        count_wide     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctrl.cmp   = 1'b1;
                state_next = S_RED;
            end
            S_RED:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (can_load)
                begin
                    out_next.found       = 1'b0;
                    out_next.found_value = '0;
                    out_next.status      = ST_DONE;
                    case (cmd_reg.command)
                        CMD_INSERT:
                        begin
                            if (hit)
                            begin
                                out_next.found = 1'b1;
                                ctrl.rep       = 1'b1;
                            end
                            else if (full)
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.ins   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_FIND:
                        begin
                            if (hit)
                            begin
                                out_next.found       = 1'b1;
                                out_next.found_value = hit_value;
                            end
                            else
                            begin
                                out_next.status = ST_MISSING;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (hit)
                            begin
                                out_next.found = 1'b1;
                                ctrl.del       = 1'b1;
                                count_next     = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                out_next.status = ST_MISSING;
                            end
                        end
                        default:
                        begin
                            out_next.status = ST_DONE;
                        end
                    endcase
                    count_wide           = {{ENTRY_COUNT_W{1'b0}}, count_next};
                    out_next.entry_count = count_wide[ENTRY_COUNT_W-1:0];
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

`ifndef SYNTH
    // Count never passes the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Sorted distinct keys give at most one match
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED) |-> $onehot0(eq_vec))
        else $error("more than one cell matched the key");

    // An accepted item starts the compare step next cycle
    a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_CMP))
        else $error("accepted item did not start compare");

    // A full rejection only with a full table
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == ST_FULL)) |-> full)
        else $error("full status with free slots");

    // A change of the stored count always comes with a result
    a_count_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (count_next != count_reg)) |=> out_valid_reg)
        else $error("count changed without a result");
`endif

endmodule

`default_nettype wire
